// ----- rtl/ctcg_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ctcg_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLASS_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DICT_SIZE   = 1'b1;

  // Register reset values
  localparam logic [15:0] CLASS_COUNT_RST = 16'd32768;
  localparam logic [14:0] DICT_SIZE_RST   = 15'd32767;

  // Field widths
  localparam int unsigned PROB_W  = 16;
  localparam int unsigned SYM_W   = 15;
  localparam int unsigned SUM_W   = 24;
  localparam int unsigned COUNT_W = 9;
  localparam int unsigned DATA_W  = 32;

  // Previous-class marker for "no row seen yet in this sequence"
  localparam logic [15:0] NO_CLASS = 16'hFFFF;

  // Saturation limits
  localparam logic [SUM_W-1:0]   SUM_MAX   = 24'hFFFFFF;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 9'd511;

  // Result kinds
  localparam logic KIND_SYMBOL = 1'b0;
  localparam logic KIND_MEAN   = 1'b1;

  // Event queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = 2;

  // One row-end event: a symbol to emit, a sequence end, or both
  typedef struct packed {
    logic              emit;
    logic              seq_end;
    logic [SYM_W-1:0]  symbol;
    logic [PROB_W-1:0] score;
  } ctcg_evt_t;

endpackage

`default_nettype wire

// ----- rtl/ctc_greedy_decoder_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// CTC greedy decoder. One class probability (unsigned Q0.16) is taken per
// cycle on the slave stream while the event queue is not full, class_count
// values per time step, tlast marking the final time step of a sequence
// (sampled on the row's last value only). Each row's arg-max (first maximum
// wins) is emitted as a symbol word (tuser 0, symbol = class - 1) when it is
// not blank, not a repeat of the previous row and below dict_size. After the
// final row a mean word follows (tuser 1, tlast 1) holding floor(sum/count)
// of the emitted scores, or 0. Row-end events go through a 4-entry queue to
// the back, which loads a symbol event into the output register as it pops
// it; on a sequence end it takes the event, runs the bit-serial divider and
// then loads the mean word, popping nothing further until that is done. The
// front stalls only when that queue is full. Configuration writes are taken
// any cycle and must be made while idle.
module ctc_greedy_decoder_unit
  import ctcg_pkg::*;
#(
  parameter int unsigned MAX_CLASSES = 32768
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // configuration write channel
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [15:0]          cfg_data_i,
  // probability stream
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [15:0]          s_axis_tdata,  // [15:0] prob_value
  input  wire logic                 s_axis_tlast,  // last_step
  // result stream
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic [DATA_W-1:0]         m_axis_tdata,  // [14:0] symbol, [30:15] score
  output logic                      m_axis_tuser,  // kind
  output logic                      m_axis_tlast   // last
);

  logic        push, full, pop, empty;
  ctcg_evt_t   push_data, head;
  logic [SYM_W-1:0]  out_symbol;
  logic [PROB_W-1:0] out_score;

  ctcg_front #(
    .MAX_CLASSES (MAX_CLASSES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_o   (s_axis_tready),
    .s_prob_i    (s_axis_tdata),
    .s_last_i    (s_axis_tlast),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  ctcg_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .head_o      (head)
  );

  ctcg_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .empty_i    (empty),
    .head_i     (head),
    .pop_o      (pop),
    .m_valid_o  (m_axis_tvalid),
    .m_ready_i  (m_axis_tready),
    .m_kind_o   (m_axis_tuser),
    .m_symbol_o (out_symbol),
    .m_score_o  (out_score),
    .m_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, out_score, out_symbol};

endmodule

`default_nettype wire

// ----- rtl/ctcg_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ctcg_fifo
  import ctcg_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire ctcg_evt_t push_data_i,
  output logic           full_o,
  input  wire logic      pop_i,
  output logic           empty_o,
  output ctcg_evt_t      head_o
);

  ctcg_evt_t                mem_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]      wr_ptr_q, rd_ptr_q;
  logic [QUEUE_AW:0]        count_q;

  assign full_o  = (count_q == (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push_i && !pop_i)      count_q <= count_q + 1'b1;
      else if (!push_i && pop_i) count_q <= count_q - 1'b1;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o && !pop_i))
    else $error("event queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("event queue underflow");

  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (QUEUE_AW + 1)'(QUEUE_DEPTH))
    else $error("event queue level out of range");

endmodule

`default_nettype wire

// ----- rtl/ctcg_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ctcg_front
  import ctcg_pkg::*;
#(
  parameter int unsigned MAX_CLASSES = 32768
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // configuration
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [15:0]          cfg_data_i,
  // probability stream
  input  wire logic                 s_valid_i,
  output logic                      s_ready_o,
  input  wire logic [PROB_W-1:0]    s_prob_i,
  input  wire logic                 s_last_i,
  // event queue
  output logic                      push_o,
  output ctcg_evt_t                 push_data_o,
  input  wire logic                 full_i
);

  localparam int unsigned CLS_W = $clog2(MAX_CLASSES);

  logic [15:0]       class_count_q;
  logic [SYM_W-1:0]  dict_size_q;
  logic [PROB_W-1:0] best_value_q;
  logic [CLS_W-1:0]  best_class_q;
  logic [CLS_W-1:0]  position_q;
  logic [15:0]       prev_class_q;

  logic              accept;
  logic [CLS_W-1:0]  row_last_pos;
  logic              row_end;
  logic              take_new;
  logic [PROB_W-1:0] best_value_d;
  logic [CLS_W-1:0]  best_class_d;
  logic [16:0]       sym_full;
  logic              emit;

  assign cfg_ready_o = 1'b1;
  assign s_ready_o   = !full_i;
  assign accept      = s_valid_i && s_ready_o;

  // Last class index of a row; zero count acts as one, large counts clip
  always_comb begin
    if (class_count_q == '0) begin
      row_last_pos = '0;
    end else if ({1'b0, class_count_q} >= 17'(MAX_CLASSES)) begin
      row_last_pos = CLS_W'(MAX_CLASSES - 1);
    end else begin
      row_last_pos = CLS_W'(class_count_q - 16'd1);
    end
  end

  // Running arg-max, first maximum wins
  assign row_end      = (position_q == row_last_pos);
  assign take_new     = (position_q == '0) || (s_prob_i > best_value_q);
  assign best_value_d = take_new ? s_prob_i : best_value_q;
  assign best_class_d = take_new ? position_q : best_class_q;

  // Emit decision at row end
  assign sym_full = 17'(best_class_d) - 17'd1;
  assign emit     = (best_class_d != '0) && (16'(best_class_d) != prev_class_q) &&
                    (sym_full < 17'(dict_size_q));

  assign push_o             = accept && row_end && (emit || s_last_i);
  assign push_data_o.emit    = emit;
  assign push_data_o.seq_end = s_last_i;
  assign push_data_o.symbol  = sym_full[SYM_W-1:0];
  assign push_data_o.score   = best_value_d;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      class_count_q <= CLASS_COUNT_RST;
      dict_size_q   <= DICT_SIZE_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_CLASS_COUNT: class_count_q <= cfg_data_i;
        CFG_DICT_SIZE:   dict_size_q   <= cfg_data_i[SYM_W-1:0];
        default: ;
      endcase
    end
  end

  // Row state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_value_q <= '0;
      best_class_q <= '0;
      position_q   <= '0;
      prev_class_q <= NO_CLASS;
    end else if (accept) begin
      best_value_q <= best_value_d;
      best_class_q <= best_class_d;
      if (row_end) begin
        position_q   <= '0;
        prev_class_q <= s_last_i ? NO_CLASS : 16'(best_class_d);
      end else begin
        position_q <= position_q + 1'b1;
      end
    end
  end

  a_pos_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    position_q <= row_last_pos || $past(cfg_valid_i))
    else $error("class position beyond row end");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> !full_i)
    else $error("event pushed into full queue");

  a_push_on_row_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> row_end && accept)
    else $error("event pushed off a row boundary");

endmodule

`default_nettype wire

// ----- rtl/ctcg_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ctcg_back
  import ctcg_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // event queue
  input  wire logic        empty_i,
  input  wire ctcg_evt_t   head_i,
  output logic             pop_o,
  // result stream
  output logic             m_valid_o,
  input  wire logic        m_ready_i,
  output logic             m_kind_o,
  output logic [SYM_W-1:0] m_symbol_o,
  output logic [PROB_W-1:0] m_score_o,
  output logic             m_last_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_MEAN
  } state_e;

  localparam int unsigned STEP_W = $clog2(SUM_W);

  state_e              state_q;
  logic [SUM_W-1:0]    sum_q;
  logic [COUNT_W-1:0]  count_q;
  logic [SUM_W-1:0]    quo_q;
  logic [COUNT_W-1:0]  div_q;
  logic [COUNT_W-1:0]  rem_q;
  logic [STEP_W-1:0]   step_q;
  logic                out_valid_q;
  logic                out_kind_q;
  logic [SYM_W-1:0]    out_symbol_q;
  logic [PROB_W-1:0]   out_score_q;
  logic                out_last_q;

  logic                out_free;
  logic                out_load;
  logic [SUM_W:0]      sum_add;
  logic [SUM_W-1:0]    sum_d;
  logic [COUNT_W-1:0]  count_d;
  logic [COUNT_W:0]    trial;
  logic                trial_ge;
  logic [PROB_W-1:0]   mean;

  assign out_free = !out_valid_q || m_ready_i;
  assign pop_o    = (state_q == S_IDLE) && !empty_i && (out_free || !head_i.emit);

  // Output register gets a new word: symbol on pop, or the finished mean
  assign out_load = (pop_o && head_i.emit) || ((state_q == S_MEAN) && out_free);

  // Saturating accumulate for an emitted symbol
  assign sum_add = {1'b0, sum_q} + (SUM_W + 1)'(head_i.score);
  always_comb begin
    sum_d   = sum_q;
    count_d = count_q;
    if (head_i.emit) begin
      sum_d   = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
      count_d = (count_q == COUNT_MAX) ? COUNT_MAX : count_q + 1'b1;
    end
  end

  // Restoring division step, one quotient bit per cycle
  assign trial    = {rem_q, quo_q[SUM_W-1]};
  assign trial_ge = (trial >= {1'b0, div_q});

  // Mean with empty sequence giving zero, clipped to 16 bits
  always_comb begin
    if (div_q == '0) begin
      mean = '0;
    end else if (quo_q[SUM_W-1:PROB_W] != '0) begin
      mean = '1;
    end else begin
      mean = quo_q[PROB_W-1:0];
    end
  end

  // Sequencer, accumulators and output word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      sum_q        <= '0;
      count_q      <= '0;
      quo_q        <= '0;
      div_q        <= '0;
      rem_q        <= '0;
      step_q       <= '0;
      out_valid_q  <= 1'b0;
      out_kind_q   <= KIND_SYMBOL;
      out_symbol_q <= '0;
      out_score_q  <= '0;
      out_last_q   <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (pop_o) begin
            if (head_i.emit) begin
              out_kind_q   <= KIND_SYMBOL;
              out_symbol_q <= head_i.symbol;
              out_score_q  <= head_i.score;
              out_last_q   <= 1'b0;
            end
            if (head_i.seq_end) begin
              quo_q   <= sum_d;
              div_q   <= count_d;
              rem_q   <= '0;
              step_q  <= '0;
              sum_q   <= '0;
              count_q <= '0;
              state_q <= S_DIV;
            end else begin
              sum_q   <= sum_d;
              count_q <= count_d;
            end
          end
        end
        S_DIV: begin
          rem_q  <= trial_ge ? COUNT_W'(trial - {1'b0, div_q}) : trial[COUNT_W-1:0];
          quo_q  <= {quo_q[SUM_W-2:0], trial_ge};
          step_q <= step_q + 1'b1;
          if (step_q == STEP_W'(SUM_W - 1)) state_q <= S_MEAN;
        end
        S_MEAN: begin
          if (out_free) begin
            out_kind_q   <= KIND_MEAN;
            out_symbol_q <= '0;
            out_score_q  <= mean;
            out_last_q   <= 1'b1;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_valid_o  = out_valid_q;
  assign m_kind_o   = out_kind_q;
  assign m_symbol_o = out_symbol_q;
  assign m_score_o  = out_score_q;
  assign m_last_o   = out_last_q;

  a_sum_needs_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (sum_q == '0))
    else $error("confidence sum without emitted symbols");

  a_no_pop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !pop_o)
    else $error("queue popped while divider busy");

  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && div_q != '0) |-> (rem_q < div_q))
    else $error("division remainder out of range");

endmodule

`default_nettype wire
